// ===== rtl/dcc_pkg.sv =====
// Shared constants for the de Casteljau curve point evaluator.
package dcc_pkg;

   localparam int COORD_W          = 24;
   localparam int MAX_POINTS_DEF   = 6;
   localparam int T_FRAC_BITS_DEF  = 16;

   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 2 * COORD_W;
   localparam int PIU_W            = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_FIRST   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_LAST    = 3'd6;

   localparam logic [PIU_W-1:0]     POINTS_RESET      = 3'd6;

endpackage

// ===== rtl/dcc_lerp_cell.sv =====
// One de Casteljau level: interpolate adjacent points or pass them, register.
module dcc_lerp_cell #(
   parameter int MAX_POINTS  = dcc_pkg::MAX_POINTS_DEF,
   parameter int T_FRAC_BITS = dcc_pkg::T_FRAC_BITS_DEF,
   parameter int LEVEL       = 1
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  logic [$clog2(MAX_POINTS)-1:0]                      in_levels,
   input  logic [T_FRAC_BITS:0]                               in_t,
   input  logic [MAX_POINTS-1:0][dcc_pkg::COORD_W-1:0]        in_x,
   input  logic [MAX_POINTS-1:0][dcc_pkg::COORD_W-1:0]        in_y,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output logic [$clog2(MAX_POINTS)-1:0]                      out_levels,
   output logic [T_FRAC_BITS:0]                               out_t,
   output logic [MAX_POINTS-1:0][dcc_pkg::COORD_W-1:0]        out_x,
   output logic [MAX_POINTS-1:0][dcc_pkg::COORD_W-1:0]        out_y
);

   localparam int CW     = dcc_pkg::COORD_W;
   localparam int T_W    = T_FRAC_BITS + 1;
   localparam int LVL_W  = $clog2(MAX_POINTS);
   localparam int LERPS  = MAX_POINTS - LEVEL;
   localparam int PROD_W = CW + 1 + T_W + 1;

   logic                               valid_ff, valid_in;
   logic [LVL_W-1:0]                   levels_ff;
   logic [T_W-1:0]                     t_ff;
   logic [MAX_POINTS-1:0][CW-1:0]      x_ff, x_in;
   logic [MAX_POINTS-1:0][CW-1:0]      y_ff, y_in;
   logic                               active;
   logic                               take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign active   = (in_levels >= LVL_W'(LEVEL));
   assign valid_in = take ? 1'b1 : (valid_ff && !out_ready);

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_pt
      if (i < LERPS) begin : g_lerp
         logic signed [CW:0]       diff_x, diff_y;
         logic signed [T_W:0]      t_s;
         logic signed [PROD_W-1:0] prod_x, prod_y;
         logic signed [PROD_W-1:0] step_x, step_y;

         assign t_s    = $signed({1'b0, in_t});
         assign diff_x = $signed({1'b0, in_x[i+1]}) - $signed({1'b0, in_x[i]});
         assign diff_y = $signed({1'b0, in_y[i+1]}) - $signed({1'b0, in_y[i]});
         assign prod_x = PROD_W'(diff_x) * PROD_W'(t_s);
         assign prod_y = PROD_W'(diff_y) * PROD_W'(t_s);
         assign step_x = prod_x >>> T_FRAC_BITS;
         assign step_y = prod_y >>> T_FRAC_BITS;
         assign x_in[i] = active ? (in_x[i] + step_x[CW-1:0]) : in_x[i];
         assign y_in[i] = active ? (in_y[i] + step_y[CW-1:0]) : in_y[i];
      end else begin : g_pass
         assign x_in[i] = in_x[i];
         assign y_in[i] = in_y[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         levels_ff <= in_levels;
         t_ff      <= in_t;
         x_ff      <= x_in;
         y_ff      <= y_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_levels = levels_ff;
   assign out_t      = t_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid)
      else $error("cell lost an accepted request");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && !in_valid |=> !out_valid)
      else $error("cell kept a delivered request");

   a_idle_level_passes: assert property (@(posedge clock) disable iff (reset)
      take && !active |=> out_x == $past(in_x) && out_y == $past(in_y))
      else $error("inactive level altered points");

endmodule

// ===== rtl/de_casteljau_curve_point.sv =====
// Top level: control point registers and a chain of de Casteljau level cells.
// Pipeline: MAX_POINTS-1 triangle level cells (5 by default) between request accept
// and result valid, each cell registering its level.
// Throughput: one request per cycle while rsp_tready does not stall the chain; every level has its own multipliers.
// Reset: points_in_use returns to 6, all control points to zero, pipeline empties.
module de_casteljau_curve_point #(
   parameter int MAX_POINTS  = dcc_pkg::MAX_POINTS_DEF,
   parameter int T_FRAC_BITS = dcc_pkg::T_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((T_FRAC_BITS+8)/8)*8-1:0]     req_tdata,  // param_t
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*dcc_pkg::COORD_W-1:0]        rsp_tdata,  // curve_y (high), curve_x (low)
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dcc_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CW    = dcc_pkg::COORD_W;
   localparam int T_W   = T_FRAC_BITS + 1;
   localparam int LVL_W = $clog2(MAX_POINTS);
   localparam int CNT_W = 5;
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

   logic [dcc_pkg::PIU_W-1:0]      piu_ff;
   logic [MAX_POINTS-1:0][CW-1:0]  px_ff;
   logic [MAX_POINTS-1:0][CW-1:0]  py_ff;
   logic                           csr_wr;

   logic [T_W-1:0]                 t_raw, t_sat;
   logic [CNT_W-1:0]               n_raw, n_eff;

   logic                           st_valid  [MAX_POINTS];
   logic                           st_ready  [MAX_POINTS];
   logic [LVL_W-1:0]               st_levels [MAX_POINTS];
   logic [T_W-1:0]                 st_t      [MAX_POINTS];
   logic [MAX_POINTS-1:0][CW-1:0]  st_x      [MAX_POINTS];
   logic [MAX_POINTS-1:0][CW-1:0]  st_y      [MAX_POINTS];

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         piu_ff <= dcc_pkg::POINTS_RESET;
         px_ff  <= '0;
         py_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_index == dcc_pkg::CSR_POINTS_IN_USE) begin
            piu_ff <= csr_data[dcc_pkg::PIU_W-1:0];
         end
         for (int k = 0; k < MAX_POINTS; k++) begin
            if (k <= int'(dcc_pkg::CSR_POINT_LAST - dcc_pkg::CSR_POINT_FIRST) &&
                int'(csr_index) == k + int'(dcc_pkg::CSR_POINT_FIRST)) begin
               px_ff[k] <= csr_data[2*CW-1:CW];
               py_ff[k] <= csr_data[CW-1:0];
            end
         end
      end
   end

   assign t_raw = req_tdata[T_W-1:0];
   assign t_sat = (t_raw > T_ONE) ? T_ONE : t_raw;

   assign n_raw = CNT_W'(piu_ff);
   always_comb begin
      priority if (n_raw < CNT_W'(2)) begin
         n_eff = CNT_W'(2);
      end else if (n_raw > CNT_W'(MAX_POINTS)) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = n_raw;
      end
   end

   assign st_valid[0]  = req_tvalid;
   assign req_tready   = st_ready[0];
   assign st_levels[0] = LVL_W'(n_eff - CNT_W'(1));
   assign st_t[0]      = t_sat;
   assign st_x[0]      = px_ff;
   assign st_y[0]      = py_ff;

   for (genvar g = 1; g < MAX_POINTS; g++) begin : g_cell
      dcc_lerp_cell #(
         .MAX_POINTS  (MAX_POINTS),
         .T_FRAC_BITS (T_FRAC_BITS),
         .LEVEL       (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (st_valid[g-1]),
         .in_ready   (st_ready[g-1]),
         .in_levels  (st_levels[g-1]),
         .in_t       (st_t[g-1]),
         .in_x       (st_x[g-1]),
         .in_y       (st_y[g-1]),
         .out_valid  (st_valid[g]),
         .out_ready  (st_ready[g]),
         .out_levels (st_levels[g]),
         .out_t      (st_t[g]),
         .out_x      (st_x[g]),
         .out_y      (st_y[g])
      );
   end

   assign st_ready[MAX_POINTS-1] = rsp_tready;
   assign rsp_tvalid = st_valid[MAX_POINTS-1];
   assign rsp_tdata  = {st_y[MAX_POINTS-1][0], st_x[MAX_POINTS-1][0]};

   a_piu_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_index == dcc_pkg::CSR_POINTS_IN_USE |=>
         piu_ff == $past(csr_data[dcc_pkg::PIU_W-1:0]))
      else $error("points_in_use write not taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without output back-pressure");

endmodule
